@@ sv/lse_pkg.sv @@
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types, constants and helper functions of the LFSR stream encrypter.
// ----------------------------------------------------------------------------
package lse_pkg;

  // One plaintext request as it arrives at the block.
  typedef struct packed {
    logic [7:0] plain_byte;
    logic       start_frame;
  } in_item_t;

  // One emitted byte.
  typedef struct packed {
    logic [7:0] cipher_byte;
    logic       last_of_run;
    logic       frame_overflow;
  } out_item_t;

  // Classified request as it sits in the queue between front and back end.
  // Plaintext bit 7 never reaches the output, so only bits 6:0 are kept.
  typedef struct packed {
    logic [6:0] plain;
    logic       start;
    logic [4:0] pre_count;
  } req_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_TAP_SELECT      = 2'd0,
    CFG_SEED            = 2'd1,
    CFG_PREAMBLE_LENGTH = 2'd2
  } cfg_index_t;

  localparam logic signed [7:0] PRE_MIN  = 8'sd10;
  localparam logic signed [7:0] PRE_MAX  = 8'sd26;
  localparam logic [6:0]        PRE_FILL = 7'h20;
  localparam logic [7:0]        TAP_LAST = 8'h08;
  localparam logic [7:0]        TAP_WRAP = 8'h07;

  localparam int QUEUE_DEPTH = 2;

  // Feedback tap mask; selects above the last pattern fold to their low bits.
  function automatic logic [6:0] tap_mask(input logic [7:0] sel);
    logic [7:0] s;
    logic [6:0] m;
    s = (sel > TAP_LAST) ? (sel & TAP_WRAP) : sel;
    case (s[3:0])
      4'd0:    m = 7'h60;
      4'd1:    m = 7'h48;
      4'd2:    m = 7'h78;
      4'd3:    m = 7'h72;
      4'd4:    m = 7'h6A;
      4'd5:    m = 7'h69;
      4'd6:    m = 7'h5C;
      4'd7:    m = 7'h7E;
      4'd8:    m = 7'h7B;
      default: m = 7'h60;
    endcase
    return m;
  endfunction

  // One Fibonacci step: shift left, feedback parity into bit 0.
  function automatic logic [6:0] lfsr_step(input logic [6:0] s, input logic [7:0] sel);
    return {s[5:0], ^(s & tap_mask(sel))};
  endfunction

  // Bit 7 carries the parity of bits 6:0.
  function automatic logic [7:0] with_parity(input logic [6:0] v);
    return {^v, v};
  endfunction

endpackage

@@ sv/lse_front.sv @@
// ----------------------------------------------------------------------------
// lse_front
// Classifies an incoming request and resolves its preamble length.
// ----------------------------------------------------------------------------
module lse_front (
  input  lse_pkg::in_item_t req_data,
  input  logic [7:0]        preamble_length,
  output lse_pkg::req_t     item
);

  logic signed [7:0] len;
  logic [4:0]        count;

  always_comb begin
    len = preamble_length;
    if (len < lse_pkg::PRE_MIN) begin
      count = lse_pkg::PRE_MIN[4:0];
    end else if (len > lse_pkg::PRE_MAX) begin
      count = lse_pkg::PRE_MAX[4:0];
    end else begin
      count = len[4:0];
    end
  end

  assign item.plain     = req_data.plain_byte[6:0];
  assign item.start     = req_data.start_frame;
  assign item.pre_count = count;

endmodule

@@ sv/lse_queue.sv @@
// ----------------------------------------------------------------------------
// lse_queue
// Short FIFO of classified requests between front and back end.
// ----------------------------------------------------------------------------
module lse_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lse_pkg::req_t wr_item,
  input  logic          pop,
  output lse_pkg::req_t head,
  output logic          head_valid,
  output logic          full
);

  localparam int Aw = $clog2(lse_pkg::QUEUE_DEPTH);
  localparam int Cw = $clog2(lse_pkg::QUEUE_DEPTH + 1);

  lse_pkg::req_t  entries [lse_pkg::QUEUE_DEPTH];
  logic [Aw-1:0]  wr_ptr;
  logic [Aw-1:0]  rd_ptr;
  logic [Cw-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full       = (count == Cw'(lse_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Aw'(lse_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Aw'(lse_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ sv/lse_back.sv @@
// ----------------------------------------------------------------------------
// lse_back
// Keystream sequencer: runs the LFSR, emits preamble and cipher bytes.
// ----------------------------------------------------------------------------
module lse_back #(
  parameter int FRAME_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  lse_pkg::req_t      head,
  input  logic               head_valid,
  output logic               pop,
  input  logic [7:0]         tap_select,
  input  logic [7:0]         seed,
  output logic               res_valid,
  input  logic               res_ready,
  output lse_pkg::out_item_t res_data
);

  localparam int PosW = $clog2(FRAME_BYTES + 1);

  logic [6:0]         lfsr;
  logic [PosW-1:0]    pos;
  logic [4:0]         rem;
  logic               started;

  logic               adv;
  logic               fire;
  logic               first;
  logic               in_pre;
  logic               full;
  logic [6:0]         lfsr_src;
  logic [6:0]         lfsr_nxt;
  lse_pkg::out_item_t res_next;

  always_comb begin
    adv      = !res_valid || res_ready;
    fire     = adv && head_valid;
    first    = head.start && !started;
    in_pre   = first || (started && (rem != '0));
    full     = (pos >= PosW'(FRAME_BYTES));
    lfsr_src = first ? seed[6:0] : lfsr;
    lfsr_nxt = lse_pkg::lfsr_step(lfsr_src, tap_select);
    pop      = fire && !in_pre;

    if (in_pre) begin
      res_next.cipher_byte    = lse_pkg::with_parity(lse_pkg::PRE_FILL ^ lfsr_nxt);
      res_next.last_of_run    = 1'b0;
      res_next.frame_overflow = 1'b0;
    end else if (full) begin
      res_next.cipher_byte    = '0;
      res_next.last_of_run    = 1'b1;
      res_next.frame_overflow = 1'b1;
    end else begin
      res_next.cipher_byte    = lse_pkg::with_parity(head.plain ^ lfsr_nxt);
      res_next.last_of_run    = 1'b1;
      res_next.frame_overflow = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_data <= res_next;
    end
    if (rst) begin
      lfsr      <= '0;
      pos       <= '0;
      rem       <= '0;
      started   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (adv) begin
        res_valid <= head_valid;
      end
      if (fire) begin
        // overflow leaves the LFSR and position untouched
        if (in_pre || !full) begin
          lfsr <= lfsr_nxt;
        end
        if (first) begin
          pos     <= PosW'(1);
          rem     <= head.pre_count - 5'd1;
          started <= 1'b1;
        end else begin
          if (!full) begin
            pos <= pos + 1'b1;
          end
          if (in_pre) begin
            rem <= rem - 5'd1;
          end else begin
            started <= 1'b0;
          end
        end
      end
    end
  end

endmodule

@@ sv/lfsr_stream_encrypter_core.sv @@
// ----------------------------------------------------------------------------
// lfsr_stream_encrypter_core
// Frame-based byte stream encrypter driven by a 7-bit Fibonacci LFSR.
// ----------------------------------------------------------------------------
// Each request carries one plaintext byte. A request with start_frame set
// reloads the LFSR from seed and first produces a preamble of keystream ^ 0x20
// bytes (preamble_length clamped to 10..26), then its own cipher byte; any
// other request produces one cipher byte, plaintext ^ next keystream value.
// Bit 7 of every output is the parity of bits 6:0. Once FRAME_BYTES bytes
// went out in a frame, further requests yield one zero byte flagged
// frame_overflow. last_of_run marks the final byte of each request.
// Throughput: one request per cycle for ordinary bytes while res_ready is high;
// a start-of-frame request holds the back end for preamble length + 1 bytes
// (11 to 27), one byte per cycle through the single output register. A 2-deep
// request queue lets the input side keep accepting while the back end drains a
// preamble. An accepted request is registered in the queue, then in the output
// register. Config writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module lfsr_stream_encrypter_core #(
  parameter int FRAME_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_ready,
  input  lse_pkg::in_item_t  req_data,
  // result channel
  output logic               res_valid,
  input  logic               res_ready,
  output lse_pkg::out_item_t res_data,
  // configuration write port
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [7:0]         cfg_data
);

  // configuration registers
  logic [7:0] tap_select;
  logic [7:0] seed;
  logic [7:0] preamble_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_select      <= '0;
      seed            <= '0;
      preamble_length <= 8'(lse_pkg::PRE_MIN);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lse_pkg::CFG_TAP_SELECT:      tap_select      <= cfg_data;
        lse_pkg::CFG_SEED:            seed            <= cfg_data;
        lse_pkg::CFG_PREAMBLE_LENGTH: preamble_length <= cfg_data;
        default: ; // unmapped index, write ignored
      endcase
    end
  end

  // front end: classify and resolve preamble length at acceptance
  lse_pkg::req_t item;
  lse_pkg::req_t head;
  logic          head_valid;
  logic          q_full;
  logic          pop;

  lse_front u_front (
    .req_data        (req_data),
    .preamble_length (preamble_length),
    .item            (item)
  );

  // ready only depends on queue occupancy, no path from res_ready
  assign req_ready = !q_full;

  lse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (req_valid && req_ready),
    .wr_item    (item),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  // back end: LFSR sequencer with registered output
  lse_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .tap_select (tap_select),
    .seed       (seed),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

  // every output byte carries its parity in bit 7
  a_parity: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.cipher_byte[7] == ^res_data.cipher_byte[6:0]))
    else $error("parity bit mismatch");

  // an overflow result is a zeroed, final byte
  a_overflow: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_data.frame_overflow) |->
      (res_data.last_of_run && (res_data.cipher_byte == 8'h00)))
    else $error("malformed overflow result");

  // the back end only retires a request that is present
  a_pop: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

  // a retiring request always produces a final byte on the next cycle
  a_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (res_valid && res_data.last_of_run))
    else $error("retired request without final byte");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for lfsr_stream_encrypter_core: random plaintext frames
// and register settings, every output byte checked against a tracked keystream.
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAME_BYTES = 64;
  localparam int LIMIT       = 300000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 38;
  localparam int PHASE_CAP   = 44;

  // --------------------------------------------------------------------------
  // Keystream tracker: mirrors the LFSR, frame position and registers, and
  // keeps the bytes the block still owes us, oldest first.
  // --------------------------------------------------------------------------
  class cipher_tracker;
    int                 frame_cap;
    logic [7:0]         tap_sel;
    logic [7:0]         seed_reg;
    logic signed [7:0]  pre_req;
    logic [6:0]         lfsr;
    int                 frame_pos;
    lse_pkg::out_item_t expected_bytes[$];
    int                 errors;

    function new(int cap);
      frame_cap = cap;
      tap_sel   = 8'd0;
      seed_reg  = 8'd0;
      pre_req   = 8'sd10;
      lfsr      = 7'd0;
      frame_pos = 0;
      errors    = 0;
    endfunction

    function void write_reg(lse_pkg::cfg_index_t idx, logic [7:0] v);
      case (idx)
        lse_pkg::CFG_TAP_SELECT:      tap_sel  = v;
        lse_pkg::CFG_SEED:            seed_reg = v;
        lse_pkg::CFG_PREAMBLE_LENGTH: pre_req  = v;
        default: ;
      endcase
    endfunction

    function void step_lfsr();
      logic [7:0] sel;
      logic [6:0] taps;
      // patterns past the ninth fold onto their low three bits
      sel = (tap_sel > 8'd8) ? {5'd0, tap_sel[2:0]} : tap_sel;
      case (sel)
        8'd0:    taps = 7'h60;
        8'd1:    taps = 7'h48;
        8'd2:    taps = 7'h78;
        8'd3:    taps = 7'h72;
        8'd4:    taps = 7'h6A;
        8'd5:    taps = 7'h69;
        8'd6:    taps = 7'h5C;
        8'd7:    taps = 7'h7E;
        default: taps = 7'h7B;
      endcase
      lfsr = {lfsr[5:0], ^(lfsr & taps)};
    endfunction

    function void push_byte(logic [7:0] b, logic last, logic ovf);
      lse_pkg::out_item_t e;
      e.cipher_byte    = b;
      e.last_of_run    = last;
      e.frame_overflow = ovf;
      expected_bytes.push_back(e);
    endfunction

    // Works out every byte that one accepted request causes.
    function void encrypt_request(lse_pkg::in_item_t rq);
      int         n;
      logic [6:0] v;
      if (rq.start_frame) begin
        n = (pre_req < 10) ? 10 : ((pre_req > 26) ? 26 : int'(pre_req));
        lfsr      = seed_reg[6:0];
        frame_pos = 0;
        repeat (n) begin
          step_lfsr();
          v = lfsr ^ 7'h20;
          push_byte({^v, v}, 1'b0, 1'b0);
          frame_pos++;
        end
      end
      if (frame_pos >= frame_cap) begin
        // frame full: dropped, flagged, LFSR holds
        frame_pos = frame_cap;
        push_byte(8'd0, 1'b1, 1'b1);
        return;
      end
      step_lfsr();
      v = rq.plain_byte[6:0] ^ lfsr;
      push_byte({^v, v}, 1'b1, 1'b0);
      frame_pos++;
    endfunction

    function void note_mismatch(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= 40)
        $error("%s: expected %h, actual %h", field, want, got);
    endfunction

    function void check_byte(lse_pkg::out_item_t got);
      lse_pkg::out_item_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 40)
          $error("unexpected result: cipher_byte %h", got.cipher_byte);
        return;
      end
      want = expected_bytes.pop_front();
      if (got.cipher_byte !== want.cipher_byte)
        note_mismatch("cipher_byte", want.cipher_byte, got.cipher_byte);
      if (got.last_of_run !== want.last_of_run)
        note_mismatch("last_of_run", want.last_of_run, got.last_of_run);
      if (got.frame_overflow !== want.frame_overflow)
        note_mismatch("frame_overflow", want.frame_overflow, got.frame_overflow);
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block and its wiring; every input known from time zero.
  // --------------------------------------------------------------------------
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_ready;
  lse_pkg::in_item_t  req_data  = '0;
  logic               res_valid;
  logic               res_ready = 1'b0;
  lse_pkg::out_item_t res_data;
  logic               cfg_we    = 1'b0;
  logic [1:0]         cfg_addr  = 2'd0;
  logic [7:0]         cfg_data  = 8'd0;

  cipher_tracker sb;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;   // bumped by stimulus to ask for a long receiver stall
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycle_cnt     = 0;

  lfsr_stream_encrypter_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Receiver side: random back-pressure, plus a long hold-off on request.
  // The hold is counted here so the sender keeps pushing meanwhile.
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every byte that leaves the block is checked against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready)
      sb.check_byte(res_data);
  end

  // --------------------------------------------------------------------------
  // Driver tasks. All entered and left at a falling edge; valid stays up
  // between back-to-back requests so it is never dropped and raised in one step.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [7:0] plain, input logic start);
    lse_pkg::in_item_t rq;
    rq.plain_byte  = plain;
    rq.start_frame = start;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= rq;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.encrypt_request(rq);
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed byte has come out.
  task automatic settle();
    req_valid <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input lse_pkg::cfg_index_t idx, input logic [7:0] v);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= v;
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int   phase;
    int   sent;
    int   len;
    int   i;
    int   t;
    bit   noise;
    bit   long_frame;
    bit   held;
    bit   forced;
    logic start;

    sb = new(FRAME_BYTES);
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed ----
    // no frame started yet: LFSR is zero, so output is plaintext bits 6:0 with parity
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h80, 1'b0);

    // longest preamble, widest tap set, seed with bit 7 set
    settle();
    write_reg(lse_pkg::CFG_TAP_SELECT, 8'd8);
    write_reg(lse_pkg::CFG_SEED, 8'hFF);
    write_reg(lse_pkg::CFG_PREAMBLE_LENGTH, 8'd26);
    send_request(8'h7F, 1'b1);
    send_request(8'h55, 1'b0);
    send_request(8'hAA, 1'b0);

    // tap select above 8 folds; seed of only bit 7 loads a zero LFSR;
    // most negative length clamps to the minimum
    settle();
    write_reg(lse_pkg::CFG_TAP_SELECT, 8'd9);
    write_reg(lse_pkg::CFG_SEED, 8'h80);
    write_reg(lse_pkg::CFG_PREAMBLE_LENGTH, 8'h80);
    send_request(8'h20, 1'b1);

    // one past the maximum length, largest tap select
    settle();
    write_reg(lse_pkg::CFG_TAP_SELECT, 8'hFF);
    write_reg(lse_pkg::CFG_SEED, 8'h7F);
    write_reg(lse_pkg::CFG_PREAMBLE_LENGTH, 8'd27);
    send_request(8'h01, 1'b1);

    // each feedback pattern once
    for (t = 0; t <= 8; t++) begin
      settle();
      write_reg(lse_pkg::CFG_TAP_SELECT, t[7:0]);
      write_reg(lse_pkg::CFG_SEED, 8'h5A);
      send_request(8'($urandom_range(255)), 1'b1);
    end

    // ---- random frames, three idling phases ----
    held = 1'b0;
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 18; recv_idle_pct = 70; end
        1:       begin send_idle_pct = 70; recv_idle_pct = 18; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        long_frame = ($urandom_range(5) == 0);
        forced     = 1'b0;

        if (phase == 2 && !held) begin
          // forced overflow frame under a long receiver stall
          settle();
          write_reg(lse_pkg::CFG_PREAMBLE_LENGTH, 8'h7F);
          hold_req++;
          held       = 1'b1;
          forced     = 1'b1;
          long_frame = 1'b1;
        end else if ($urandom_range(1) == 1) begin
          settle();
          if ($urandom_range(1) == 1) begin
            case ($urandom_range(5))
              0:       write_reg(lse_pkg::CFG_TAP_SELECT, 8'd0);
              1:       write_reg(lse_pkg::CFG_TAP_SELECT, 8'd8);
              2:       write_reg(lse_pkg::CFG_TAP_SELECT, 8'd9);
              3:       write_reg(lse_pkg::CFG_TAP_SELECT, 8'hFF);
              default: write_reg(lse_pkg::CFG_TAP_SELECT, 8'($urandom_range(255)));
            endcase
          end
          if ($urandom_range(1) == 1) begin
            case ($urandom_range(5))
              0:       write_reg(lse_pkg::CFG_SEED, 8'h00);
              1:       write_reg(lse_pkg::CFG_SEED, 8'h7F);
              2:       write_reg(lse_pkg::CFG_SEED, 8'h80);
              3:       write_reg(lse_pkg::CFG_SEED, 8'hFF);
              default: write_reg(lse_pkg::CFG_SEED, 8'($urandom_range(255)));
            endcase
          end
          if ($urandom_range(1) == 1) begin
            case ($urandom_range(7))
              0:       write_reg(lse_pkg::CFG_PREAMBLE_LENGTH, 8'h80);
              1:       write_reg(lse_pkg::CFG_PREAMBLE_LENGTH, 8'd9);
              2:       write_reg(lse_pkg::CFG_PREAMBLE_LENGTH, 8'd10);
              3:       write_reg(lse_pkg::CFG_PREAMBLE_LENGTH, 8'd26);
              4:       write_reg(lse_pkg::CFG_PREAMBLE_LENGTH, 8'd27);
              5:       write_reg(lse_pkg::CFG_PREAMBLE_LENGTH, 8'h7F);
              default: write_reg(lse_pkg::CFG_PREAMBLE_LENGTH,
                                 8'($urandom_range(255)));
            endcase
          end
        end

        // mostly proper frames; now and then a headless run or a stray restart;
        // the overflow frame stays clean so it really runs past the end
        noise = forced ? 1'b0 : ($urandom_range(9) == 0);
        len   = long_frame ? $urandom_range(40, 44) : $urandom_range(1, 10);
        if (len > PHASE_CAP - sent)
          len = PHASE_CAP - sent;
        for (i = 0; i < len; i++) begin
          if (i == 0)
            start = !noise;
          else
            start = forced ? 1'b0 : ($urandom_range(29) == 0);
          send_request(8'($urandom_range(255)), start);
          sent++;
        end
      end
    end

    // ---- wind down ----
    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
